### sv/tsr_pkg.sv
`default_nettype none

package tsr_pkg;

  // Default window size in bytes.
  localparam int CAPACITY_DEF = 1024;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_END  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_NOP  = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] stream_index;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       stream_done;
    logic       dropped;
  } rsp_t;

endpackage

`default_nettype wire

### sv/tsr_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module tsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/tcp_stream_reassembler_unit.sv
`default_nettype none

// Byte stream reassembler.
// The req channel carries one operation per transfer: push a byte at an
// absolute stream index, mark the index at which the stream ends, read the
// next in-order byte, or a no-op that only reports status. Every request
// produces exactly one transfer on the rsp channel.
// A request is taken in S_IDLE and its response is registered in S_EXEC once
// the response register is free; no new request is taken until it has executed.
// This is set by the read-modify-write of one ring slot: the slot is
// read from the synchronous RAMs, then updated and written back.
// After reset the presence bits are swept clear, one slot per cycle;
// req_stall stays high until the sweep is finished.
// The block takes a new request while a response still waits on rsp_stall;
// that request is then held in its execute step until the response register
// is free, and req_stall stays high meanwhile.
module tcp_stream_reassembler_unit
  import tsr_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);
  localparam logic [SW:0]   CAP_EXT   = (SW + 1)'(CAPACITY);
  localparam logic [31:0]   CAP_32    = 32'(CAPACITY);

  // Controller states.
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [SW-1:0] clr_addr;

  // Stream position state.
  logic [31:0]   read_position;
  logic [SW-1:0] read_slot;
  logic          end_known;
  logic [31:0]   end_position;

  // The request being executed.
  logic [1:0]    op_func;
  logic [31:0]   op_index;
  logic [7:0]    op_data;
  logic [SW-1:0] op_offset;
  logic          op_push_ok;
  logic          op_end_ok;

  logic          req_accept;
  logic          exec_go;
  logic [31:0]   req_offset;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] push_slot;
  logic [SW-1:0] next_slot;
  logic          cur_done;
  logic          read_ok;
  logic          push_wr;

  logic [31:0]   read_position_next;
  logic [SW-1:0] read_slot_next;
  logic          end_known_next;
  logic [31:0]   end_position_next;
  logic          done_next;

  logic          pres_wr_en;
  logic [SW-1:0] pres_wr_addr;
  logic          pres_wr_data;
  logic          pres_rd;
  logic [7:0]    byte_rd;

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign exec_go    = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  // The window test is done as the request is taken, so the execute step
  // only has to add the narrow offset to the ring slot.
  assign req_offset = req.stream_index - read_position;

  assign slot_sum  = {1'b0, read_slot} + {1'b0, op_offset};
  assign push_slot = (slot_sum >= CAP_EXT) ? SW'(slot_sum - CAP_EXT) : slot_sum[SW-1:0];
  assign next_slot = (read_slot == LAST_SLOT) ? '0 : read_slot + 1'b1;

  assign cur_done = end_known && (read_position == end_position);
  assign read_ok  = (op_func == FUNC_READ) && !cur_done && pres_rd;
  assign push_wr  = (op_func == FUNC_PUSH) && op_push_ok;

  // Position state after this request.
  always_comb begin
    read_position_next = read_position;
    read_slot_next     = read_slot;
    end_known_next     = end_known;
    end_position_next  = end_position;
    unique case (op_func) inside
      FUNC_END: begin
        if (op_end_ok) begin
          end_known_next    = 1'b1;
          end_position_next = op_index;
        end
      end
      FUNC_READ: begin
        if (read_ok) begin
          read_position_next = read_position + 32'd1;
          read_slot_next     = next_slot;
        end
      end
      FUNC_PUSH, FUNC_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign done_next = end_known_next && (read_position_next == end_position_next);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      read_position <= '0;
      read_slot     <= '0;
      end_known     <= 1'b0;
      end_position  <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (exec_go) begin
        read_position <= read_position_next;
        read_slot     <= read_slot_next;
        end_known     <= end_known_next;
        end_position  <= end_position_next;
        rsp_valid     <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request and response payload registers.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      op_func    <= req.func;
      op_index   <= req.stream_index;
      op_data    <= req.data_byte;
      op_offset  <= req_offset[SW-1:0];
      op_push_ok <= (req_offset < CAP_32);
      op_end_ok  <= (req_offset <= CAP_32);
    end
    if (exec_go) begin
      rsp.out_byte    <= read_ok ? byte_rd : 8'd0;
      rsp.out_valid   <= read_ok;
      rsp.stream_done <= done_next;
      rsp.dropped     <= ((op_func == FUNC_PUSH) && !op_push_ok) ||
                         ((op_func == FUNC_END) && !op_end_ok);
    end
  end

  // A push sets the presence bit of its slot, a successful read clears the
  // bit of the slot it consumed; the two never happen for the same request.
  always_comb begin
    pres_wr_en   = 1'b0;
    pres_wr_addr = read_slot;
    pres_wr_data = 1'b0;
    if (state == S_CLEAR) begin
      pres_wr_en   = 1'b1;
      pres_wr_addr = clr_addr;
    end else if (exec_go && push_wr) begin
      pres_wr_en   = 1'b1;
      pres_wr_addr = push_slot;
      pres_wr_data = 1'b1;
    end else if (exec_go && read_ok) begin
      pres_wr_en = 1'b1;
    end
  end

  tsr_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_present_ram (
    .clk     (clk),
    .wr_en   (pres_wr_en),
    .wr_addr (pres_wr_addr),
    .wr_data (pres_wr_data),
    .rd_en   (req_accept),
    .rd_addr (read_slot),
    .rd_data (pres_rd)
  );

  tsr_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_byte_ram (
    .clk     (clk),
    .wr_en   (exec_go && push_wr),
    .wr_addr (push_slot),
    .wr_data (op_data),
    .rd_en   (req_accept),
    .rd_addr (read_slot),
    .rd_data (byte_rd)
  );

endmodule

`default_nettype wire
